/* sv/rltt_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rltt_pkg
// Shared types and codes for the task timer table.
// ---------------------------------------------------------------------------
package rltt_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_ENABLE = 3'd2,
    OP_INVOKE = 3'd3,
    OP_CHECK  = 3'd4,
    OP_RETIME = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_FIRE = 2'd1,
    KIND_REM  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_ONE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic find_step; // advance free-slot search
    logic do_one;    // execute single-slot operation and report
    logic scan_step; // process one slot of a check
    logic done;      // report done or plain acknowledge
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic find_end;
    logic scan_end;
  } stat_t;

endpackage
`default_nettype wire

/* sv/rltt_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rltt_ctrl
// Sequencer: decodes the operation and steps the datapath.
// ---------------------------------------------------------------------------
module rltt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [2:0]     in_operation,
  input  wire logic           halted,
  input  wire rltt_pkg::stat_t stat,
  output logic                busy,
  output rltt_pkg::cmd_t      cmd
);
  import rltt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (in_operation)
            OP_ADD:    state_nxt = ST_FIND;
            OP_REMOVE, OP_ENABLE, OP_INVOKE: state_nxt = ST_ONE;
            OP_CHECK:  state_nxt = halted ? ST_DONE : ST_SCAN;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FIND: begin
        cmd.find_step = 1'b1;
        if (stat.find_end) state_nxt = ST_ONE;
      end
      ST_ONE: begin
        cmd.do_one = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.done  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> busy)
    else $error("start not taken");
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("several commands at once");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> !busy)
    else $error("done did not return to idle");

endmodule
`default_nettype wire

/* sv/rltt_dp.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rltt_dp
// Slot table, one-slot-a-cycle search and scan, result register.
// ---------------------------------------------------------------------------
module rltt_dp #(
  parameter int TABLE_DEPTH = 16,
  parameter int DATA_BITS   = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rltt_pkg::cmd_t       cmd,
  output rltt_pkg::stat_t           stat,
  input  wire logic [2:0]           in_operation,
  input  wire logic [4:0]           in_slot_id,
  input  wire logic [15:0]          in_task_type,
  input  wire logic [31:0]          in_interval,
  input  wire logic [15:0]          in_max_tries,
  input  wire logic [DATA_BITS-1:0] in_task_data,
  input  wire logic                 in_start_enabled,
  input  wire logic                 in_remove_success,
  input  wire logic [31:0]          in_now_time,
  input  wire logic                 halted,
  output logic                      out_valid,
  output logic [1:0]                out_result_kind,
  output logic                      out_ok,
  output logic [4:0]                out_result_slot,
  output logic [15:0]               out_result_type,
  output logic [31:0]               out_result_due,
  output logic [15:0]               out_result_tries,
  output logic [15:0]               out_result_max_tries,
  output logic [DATA_BITS-1:0]      out_result_data,
  output logic                      out_result_success,
  output logic                      out_last
);
  import rltt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [15:0]          type_m  [TABLE_DEPTH];
  logic [31:0]          due_m   [TABLE_DEPTH];
  logic [15:0]          tries_m [TABLE_DEPTH];
  logic [15:0]          limit_m [TABLE_DEPTH];
  logic [31:0]          ivl_m   [TABLE_DEPTH];
  logic [DATA_BITS-1:0] data_m  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] en_r;

  // captured item
  logic [2:0]           op_r;
  logic [4:0]           id_r;
  logic [15:0]          type_r, max_r;
  logic [31:0]          ivl_r, now_r;
  logic [DATA_BITS-1:0] data_r;
  logic                 sen_r, succ_r;
  logic [IW-1:0]        idx_r;
  logic                 found_r;

  logic [IW-1:0] cur;
  logic          id_ok;
  assign id_ok = (id_r != 5'd0) && ({1'b0, id_r} <= 6'(TABLE_DEPTH))
                 && valid_r[IW'(id_r - 5'd1)];
  assign cur   = (op_r == OP_ADD) ? idx_r : IW'(id_r - 5'd1);

  logic last_idx;
  assign last_idx = ({1'b0, idx_r} == (IW + 1)'(TABLE_DEPTH - 1));
  assign stat.find_end = !valid_r[idx_r] || last_idx;
  assign stat.scan_end = last_idx;

  // scan decisions for slot idx_r
  logic s_act, s_live, s_fire;
  logic [31:0] s_due;
  logic [15:0] s_tries;
  assign s_act   = valid_r[idx_r] && en_r[idx_r];
  assign s_live  = (limit_m[idx_r] == 16'd0) || (tries_m[idx_r] < limit_m[idx_r]);
  assign s_fire  = s_act && s_live && (due_m[idx_r] < now_r);
  assign s_due   = now_r + ivl_m[idx_r];
  assign s_tries = (tries_m[idx_r] == 16'hFFFF) ? tries_m[idx_r] : tries_m[idx_r] + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      out_valid <= 1'b0;
      idx_r     <= '0;
      found_r   <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cmd.load) begin
        op_r <= in_operation; id_r <= in_slot_id; type_r <= in_task_type;
        max_r <= in_max_tries; ivl_r <= in_interval; now_r <= in_now_time;
        data_r <= in_task_data; sen_r <= in_start_enabled;
        succ_r <= in_remove_success; idx_r <= '0; found_r <= 1'b0;
        if (in_operation == OP_RETIME)
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (valid_r[i]) due_m[i] <= in_now_time;
      end
      if (cmd.find_step) begin
        if (!valid_r[idx_r]) found_r <= 1'b1;
        else if (!last_idx) idx_r <= idx_r + 1'b1;
      end
      if (cmd.scan_step) begin
        if (!last_idx) idx_r <= idx_r + 1'b1;
        out_result_slot <= 5'(idx_r) + 5'd1;
        out_result_type <= type_m[idx_r];
        out_result_max_tries <= limit_m[idx_r];
        out_result_data <= data_m[idx_r];
        out_result_success <= 1'b0;
        out_ok <= 1'b1;
        out_last <= 1'b0;
        if (s_fire) begin
          due_m[idx_r]   <= s_due;
          tries_m[idx_r] <= s_tries;
          out_valid <= 1'b1; out_result_kind <= KIND_FIRE;
          out_result_due <= s_due; out_result_tries <= s_tries;
        end else if (s_act && !s_live) begin
          valid_r[idx_r] <= 1'b0;
          out_valid <= 1'b1; out_result_kind <= KIND_REM;
          out_result_due <= due_m[idx_r]; out_result_tries <= tries_m[idx_r];
        end
      end
      if (cmd.do_one || cmd.done) begin
        out_valid <= 1'b1; out_last <= 1'b1;
        out_result_kind <= KIND_ACK; out_result_success <= 1'b0;
        out_ok <= 1'b0; out_result_slot <= '0; out_result_type <= '0;
        out_result_due <= '0; out_result_tries <= '0;
        out_result_max_tries <= '0; out_result_data <= '0;
        if (cmd.done)
          out_ok <= ((op_r == OP_CHECK) && !halted) || (op_r == OP_RETIME);
        if (cmd.do_one) begin
          if (op_r == OP_ADD) begin
            if (found_r) begin
              valid_r[cur] <= 1'b1; type_m[cur] <= type_r; due_m[cur] <= '0;
              tries_m[cur] <= '0; limit_m[cur] <= max_r; ivl_m[cur] <= ivl_r;
              data_m[cur] <= data_r; en_r[cur] <= sen_r;
              out_ok <= 1'b1; out_result_slot <= 5'(cur) + 5'd1;
              out_result_type <= type_r; out_result_max_tries <= max_r;
              out_result_data <= data_r;
            end
          end else if (id_ok) begin
            out_ok <= 1'b1; out_result_slot <= id_r;
            out_result_type <= type_m[cur]; out_result_due <= due_m[cur];
            out_result_tries <= tries_m[cur];
            out_result_max_tries <= limit_m[cur]; out_result_data <= data_m[cur];
            if (op_r == OP_REMOVE) begin
              valid_r[cur] <= 1'b0; out_result_kind <= KIND_REM;
              out_result_success <= succ_r;
            end else if (op_r == OP_ENABLE) begin
              en_r[cur] <= 1'b1;
            end else begin
              due_m[cur] <= '0; out_result_due <= '0;
            end
          end
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |=> !out_valid || !out_last)
    else $error("scan result marked last");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_one || cmd.done) |=> out_valid && out_last)
    else $error("final result missing");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_one && op_r == OP_ADD && found_r) |=> valid_r[$past(cur)])
    else $error("added slot not valid");

endmodule
`default_nettype wire

/* sv/retry_limited_task_timer_table_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// retry_limited_task_timer_table_core
// Table of timed tasks with try limits: add, remove, enable, invoke, check,
// retime.
// ---------------------------------------------------------------------------
// Remove/enable/invoke: result registered from ST_ONE; retime, unused codes and a halted
// check: result registered from ST_DONE. Add: free-slot search visits one slot a cycle,
// then ST_ONE. Check: one slot a cycle through ST_SCAN, then the done result from ST_DONE.
// One item at a time; busy falls in the cycle the last result is shown.
// Reset (synchronous, rst_n low): table empty, halted set. Results cannot be
// stalled.
module retry_limited_task_timer_table_core #(
  parameter int TABLE_DEPTH = 16,
  parameter int DATA_BITS   = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [2:0]           in_operation,
  input  wire logic [4:0]           in_slot_id,
  input  wire logic [15:0]          in_task_type,
  input  wire logic [31:0]          in_interval,
  input  wire logic [15:0]          in_max_tries,
  input  wire logic [DATA_BITS-1:0] in_task_data,
  input  wire logic                 in_start_enabled,
  input  wire logic                 in_remove_success,
  input  wire logic [31:0]          in_now_time,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_wdata,
  output logic                      out_valid,
  output logic [1:0]                out_result_kind,
  output logic                      out_ok,
  output logic [4:0]                out_result_slot,
  output logic [15:0]               out_result_type,
  output logic [31:0]               out_result_due,
  output logic [15:0]               out_result_tries,
  output logic [15:0]               out_result_max_tries,
  output logic [DATA_BITS-1:0]      out_result_data,
  output logic                      out_result_success,
  output logic                      out_last
);
  import rltt_pkg::*;

  logic  halted_r;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) halted_r <= 1'b1;
    else if (cfg_we) halted_r <= cfg_wdata;
  end

  rltt_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_operation, .halted(halted_r), .stat, .busy, .cmd
  );

  rltt_dp #(.TABLE_DEPTH(TABLE_DEPTH), .DATA_BITS(DATA_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_operation, .in_slot_id, .in_task_type,
    .in_interval, .in_max_tries, .in_task_data, .in_start_enabled,
    .in_remove_success, .in_now_time, .halted(halted_r), .out_valid,
    .out_result_kind, .out_ok, .out_result_slot, .out_result_type,
    .out_result_due, .out_result_tries, .out_result_max_tries,
    .out_result_data, .out_result_success, .out_last
  );

endmodule
`default_nettype wire
